[rtl/cyk_pkg.sv]
package cyk_pkg;

  localparam int MAX_LEN_DEF        = 32;
  localparam int MAX_NT_DEF         = 32;
  localparam int MAX_BIN_RULES_DEF  = 128;
  localparam int MAX_TERM_RULES_DEF = 64;

  localparam int FIELD_NT_W  = 5;
  localparam int FIELD_SYM_W = 8;
  localparam int COUNT_W     = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BIN   = 2'd1,
    CMD_TERM  = 2'd2,
    CMD_BYTE  = 2'd3
  } cmd_t;

  // Datapath operation selected by the controller for the current cycle.
  typedef enum logic [3:0] {
    OP_IDLE   = 4'd0,
    OP_CLEAR  = 4'd1,
    OP_TERM   = 4'd2,
    OP_TRD    = 4'd3,
    OP_TWR    = 4'd4,
    OP_RULE   = 4'd5,
    OP_RD     = 4'd6,
    OP_MUL    = 4'd7,
    OP_ACC    = 4'd8,
    OP_FINAL  = 4'd9
  } op_t;

  typedef struct packed {
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_sts_t;

endpackage

[rtl/cyk_datapath.sv]
module cyk_datapath #(
  parameter int MAX_LEN        = cyk_pkg::MAX_LEN_DEF,
  parameter int MAX_NT         = cyk_pkg::MAX_NT_DEF,
  parameter int MAX_BIN_RULES  = cyk_pkg::MAX_BIN_RULES_DEF,
  parameter int MAX_TERM_RULES = cyk_pkg::MAX_TERM_RULES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           ld_valid,
  input  cyk_pkg::cmd_t                  ld_cmd,
  input  logic [cyk_pkg::FIELD_NT_W-1:0] ld_parent,
  input  logic [cyk_pkg::FIELD_NT_W-1:0] ld_left,
  input  logic [cyk_pkg::FIELD_NT_W-1:0] ld_right,
  input  logic [cyk_pkg::FIELD_SYM_W-1:0] ld_sym,
  input  logic                           str_done,
  input  cyk_pkg::dp_cmd_t               cmd,
  output cyk_pkg::dp_sts_t               sts,
  output logic                           ovf_pending,
  output logic [cyk_pkg::COUNT_W-1:0]    res_count,
  output logic                           res_too_long
);

  localparam int LW   = $clog2(MAX_LEN);
  localparam int LCW  = $clog2(MAX_LEN + 1);
  localparam int NW   = (MAX_NT > 1) ? $clog2(MAX_NT) : 1;
  localparam int BW   = (MAX_BIN_RULES > 1) ? $clog2(MAX_BIN_RULES) : 1;
  localparam int BCW  = $clog2(MAX_BIN_RULES + 1);
  localparam int TW   = (MAX_TERM_RULES > 1) ? $clog2(MAX_TERM_RULES) : 1;
  localparam int TCW  = $clog2(MAX_TERM_RULES + 1);
  localparam int RCW  = (BCW > TCW) ? BCW : TCW;
  localparam int CDEP = MAX_LEN * MAX_LEN * MAX_NT;
  localparam int CAW  = $clog2(CDEP);
  localparam int CW   = cyk_pkg::COUNT_W;

  // Rule, string and chart stores.
  logic [3*NW-1:0]                  bin_mem [MAX_BIN_RULES];
  logic [NW+cyk_pkg::FIELD_SYM_W-1:0] term_mem [MAX_TERM_RULES];
  logic [cyk_pkg::FIELD_SYM_W-1:0]  str_mem [MAX_LEN];
  logic [CW-1:0]                    chart_mem [CDEP];

  logic [BCW-1:0] bin_cnt_r;
  logic [TCW-1:0] term_cnt_r;
  logic [LCW-1:0] str_len_r;
  logic           ovf_r;

  logic nt_ok_p, nt_ok_l, nt_ok_r;
  assign nt_ok_p = 32'(ld_parent) < 32'(MAX_NT);
  assign nt_ok_l = 32'(ld_left)   < 32'(MAX_NT);
  assign nt_ok_r = 32'(ld_right)  < 32'(MAX_NT);

  always_ff @(posedge clk) begin
    if (ld_valid && ld_cmd == cyk_pkg::CMD_BIN && 32'(bin_cnt_r) < MAX_BIN_RULES &&
        nt_ok_p && nt_ok_l && nt_ok_r) begin
      bin_mem[bin_cnt_r[BW-1:0]] <= {ld_parent[NW-1:0], ld_left[NW-1:0], ld_right[NW-1:0]};
    end
    if (ld_valid && ld_cmd == cyk_pkg::CMD_TERM && 32'(term_cnt_r) < MAX_TERM_RULES &&
        nt_ok_p) begin
      term_mem[term_cnt_r[TW-1:0]] <= {ld_parent[NW-1:0], ld_sym};
    end
    if (ld_valid && ld_cmd == cyk_pkg::CMD_BYTE && 32'(str_len_r) < MAX_LEN) begin
      str_mem[str_len_r[LW-1:0]] <= ld_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r  <= '0;
      term_cnt_r <= '0;
      str_len_r  <= '0;
      ovf_r      <= 1'b0;
    end else begin
      if (ld_valid) begin
        case (ld_cmd)
          cyk_pkg::CMD_CLEAR: begin
            bin_cnt_r  <= '0;
            term_cnt_r <= '0;
          end
          cyk_pkg::CMD_BIN: begin
            if (32'(bin_cnt_r) < MAX_BIN_RULES && nt_ok_p && nt_ok_l && nt_ok_r)
              bin_cnt_r <= bin_cnt_r + 1'b1;
          end
          cyk_pkg::CMD_TERM: begin
            if (32'(term_cnt_r) < MAX_TERM_RULES && nt_ok_p)
              term_cnt_r <= term_cnt_r + 1'b1;
          end
          cyk_pkg::CMD_BYTE: begin
            if (32'(str_len_r) < MAX_LEN) str_len_r <= str_len_r + 1'b1;
            else ovf_r <= 1'b1;
          end
          default: ;
        endcase
      end
      if (str_done) begin
        str_len_r <= '0;
        ovf_r     <= 1'b0;
      end
    end
  end

  // A byte arriving now overflows if the string is already full.
  assign ovf_pending = ovf_r || (32'(str_len_r) >= MAX_LEN);

  // Walk counters: span length, start, split, rule index; term pass uses pos and rule.
  logic [LCW-1:0] len_r, s_r, k_r;
  logic [RCW-1:0] r_r;
  logic [CAW:0]   clr_r;
  logic [LCW-1:0] e_w;
  logic [LCW-1:0] n_w;
  assign n_w = str_len_r;
  assign e_w = LCW'(s_r + len_r - 1'b1);

  function automatic logic [CAW-1:0] caddr(input logic [LCW-1:0] i, input logic [LCW-1:0] j,
                                           input logic [NW-1:0] nt);
    logic [31:0] a;
    a = (32'(i) * 32'(MAX_LEN) + 32'(j)) * 32'(MAX_NT) + 32'(nt);
    return a[CAW-1:0];
  endfunction

  logic [3*NW-1:0] brule_r;
  logic [NW+cyk_pkg::FIELD_SYM_W-1:0] trule_r;
  logic [NW-1:0] b_par, b_lft, b_rgt, t_par;
  assign b_par = brule_r[3*NW-1:2*NW];
  assign b_lft = brule_r[2*NW-1:NW];
  assign b_rgt = brule_r[NW-1:0];
  assign t_par = trule_r[NW+cyk_pkg::FIELD_SYM_W-1:cyk_pkg::FIELD_SYM_W];

  logic [CW-1:0]   rd_a_r, rd_b_r, rd_c_r;
  logic [2*CW-1:0] prod_r;
  logic [CAW-1:0]  wa_r;

  // The passes have no work for an empty rule table or a string too short.
  logic term_empty, bin_empty;
  assign term_empty = (term_cnt_r == '0) || (n_w == '0);
  assign bin_empty  = (bin_cnt_r == '0) || (32'(n_w) < 2);

  // Loop advance over term pass (s_r=position, r_r=rule) and binary pass.
  logic [LCW-1:0] len_n, s_n, k_n;
  logic [RCW-1:0] r_n;
  logic           pass_end;

  always_comb begin
    len_n = len_r; s_n = s_r; k_n = k_r; r_n = r_r; pass_end = 1'b0;
    if (cmd.op == cyk_pkg::OP_TWR) begin
      if (r_r + 1'b1 >= RCW'(term_cnt_r)) begin
        r_n = '0;
        s_n = s_r + 1'b1;
        if (s_r + 1'b1 >= n_w) begin
          pass_end = 1'b1;
          s_n = '0; len_n = LCW'(2); k_n = LCW'(1);
        end
      end else r_n = r_r + 1'b1;
    end else begin
      if (r_r + 1'b1 >= RCW'(bin_cnt_r)) begin
        r_n = '0;
        if (k_r >= e_w) begin
          if (32'(s_r) + 32'(len_r) + 1 > 32'(n_w)) begin
            s_n = '0;
            len_n = len_r + 1'b1;
            if (len_r >= n_w) pass_end = 1'b1;
            k_n = LCW'(1);
          end else begin
            s_n = s_r + 1'b1;
            k_n = s_r + 2'd2;
          end
        end else k_n = k_r + 1'b1;
      end else r_n = r_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      cyk_pkg::OP_IDLE: begin
        clr_r <= '0;
        len_r <= '0; s_r <= '0; k_r <= '0; r_r <= '0;
      end
      cyk_pkg::OP_CLEAR: begin
        chart_mem[clr_r[CAW-1:0]] <= '0;
        clr_r <= clr_r + 1'b1;
      end
      cyk_pkg::OP_TERM: begin
        trule_r <= term_mem[r_r[TW-1:0]];
        if (term_empty) begin
          s_r <= '0; len_r <= LCW'(2); k_r <= LCW'(1); r_r <= '0;
        end
      end
      cyk_pkg::OP_TRD: begin
        rd_c_r <= chart_mem[caddr(s_r, s_r, t_par)];
        wa_r   <= caddr(s_r, s_r, t_par);
      end
      cyk_pkg::OP_TWR: begin
        if (trule_r[cyk_pkg::FIELD_SYM_W-1:0] == str_mem[s_r[LW-1:0]])
          chart_mem[wa_r] <= rd_c_r + 1'b1;
        s_r <= s_n; len_r <= len_n; k_r <= k_n; r_r <= r_n;
      end
      cyk_pkg::OP_RULE: begin
        brule_r <= bin_mem[r_r[BW-1:0]];
      end
      cyk_pkg::OP_RD: begin
        rd_a_r <= chart_mem[caddr(s_r, LCW'(k_r - 1'b1), b_lft)];
        rd_b_r <= chart_mem[caddr(k_r, e_w, b_rgt)];
        wa_r   <= caddr(s_r, e_w, b_par);
      end
      cyk_pkg::OP_MUL: begin
        prod_r <= (2*CW)'(rd_a_r) * (2*CW)'(rd_b_r);
        rd_c_r <= chart_mem[wa_r];
      end
      cyk_pkg::OP_ACC: begin
        chart_mem[wa_r] <= rd_c_r + prod_r[CW-1:0];
        s_r <= s_n; len_r <= len_n; k_r <= k_n; r_r <= r_n;
      end
      cyk_pkg::OP_FINAL: begin
        rd_c_r <= chart_mem[caddr('0, LCW'(n_w - 1'b1), '0)];
      end
      default: ;
    endcase
  end

  always_comb begin
    case (cmd.op)
      cyk_pkg::OP_CLEAR: sts.done = (32'(clr_r) == CDEP - 1);
      cyk_pkg::OP_TERM:  sts.done = term_empty;
      cyk_pkg::OP_TWR:   sts.done = pass_end;
      cyk_pkg::OP_RULE:  sts.done = bin_empty;
      cyk_pkg::OP_ACC:   sts.done = pass_end;
      default:           sts.done = 1'b0;
    endcase
  end

  assign res_count    = (ovf_r || n_w == '0) ? '0 : rd_c_r;
  assign res_too_long = ovf_r;

endmodule

[rtl/cyk_ctrl.sv]
module cyk_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             ovf,
  input  cyk_pkg::dp_sts_t sts,
  input  logic             out_ready,
  output cyk_pkg::dp_cmd_t cmd,
  output logic             busy,
  output logic             out_valid,
  output logic             str_done
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_TERM, S_TRD, S_TWR, S_RULE, S_RD, S_MUL, S_ACC, S_FINAL,
    S_LATCH, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = ovf ? S_LATCH : S_CLEAR;
      S_CLEAR: if (sts.done) state_nxt = S_TERM;
      S_TERM:  state_nxt = sts.done ? S_RULE : S_TRD;
      S_TRD:   state_nxt = S_TWR;
      S_TWR:   state_nxt = sts.done ? S_RULE : S_TERM;
      S_RULE:  state_nxt = sts.done ? S_FINAL : S_RD;
      S_RD:    state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = sts.done ? S_FINAL : S_RULE;
      S_FINAL: state_nxt = S_LATCH;
      S_LATCH: begin
        state_nxt = S_OUT;
        out_valid_nxt = 1'b1;
      end
      S_OUT: if (out_ready) begin
        state_nxt = S_IDLE;
        out_valid_nxt = 1'b0;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    case (state_r)
      S_CLEAR: cmd.op = cyk_pkg::OP_CLEAR;
      S_TERM:  cmd.op = cyk_pkg::OP_TERM;
      S_TRD:   cmd.op = cyk_pkg::OP_TRD;
      S_TWR:   cmd.op = cyk_pkg::OP_TWR;
      S_RULE:  cmd.op = cyk_pkg::OP_RULE;
      S_RD:    cmd.op = cyk_pkg::OP_RD;
      S_MUL:   cmd.op = cyk_pkg::OP_MUL;
      S_ACC:   cmd.op = cyk_pkg::OP_ACC;
      S_FINAL: cmd.op = cyk_pkg::OP_FINAL;
      default: cmd.op = cyk_pkg::OP_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign str_done  = (state_r == S_OUT) && out_ready;

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT) else $error("result valid outside output state");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r != S_IDLE) else $error("start lost");
  a_mul_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> $past(state_r) == S_RD) else $error("multiply without read");

endmodule

[rtl/cyk_parse_tree_counter.sv]
// Channel | Ports                        | Payload
// in      | in_tvalid/in_tready/in_tdata | cmd, rule_parent, rule_left, rule_right, symbol,
//         | in_tlast                     | is_last
// out     | out_tvalid/out_tready/out_tdata/out_tuser | tree_count, too_long
//
// Rule and byte transfers are accepted while no parse is running.
// A last byte starts a parse: a clear pass over all MAX_LEN*MAX_LEN*MAX_NT chart
// entries, then the term, read and write states per (position, terminal rule) and
// the rule, read, multiply and accumulate states per (span, split, binary rule) (a
// pass with no work ends in its first state); then the count is fetched and latched.
// A string that overflowed skips the parse; its result follows the latch state.
// Input is held off from the last byte until the result transfer completes.
// rst_n is synchronous; it empties the rule tables and the string.
module cyk_parse_tree_counter #(
  parameter int MAX_LEN        = cyk_pkg::MAX_LEN_DEF,
  parameter int MAX_NT         = cyk_pkg::MAX_NT_DEF,
  parameter int MAX_BIN_RULES  = cyk_pkg::MAX_BIN_RULES_DEF,
  parameter int MAX_TERM_RULES = cyk_pkg::MAX_TERM_RULES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] cmd, [6:2] rule_parent, [11:7] rule_left, [16:12] rule_right, [24:17] symbol
  input  logic [cyk_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [31:0] tree_count
  output logic [cyk_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] too_long
  output logic                            out_tuser
);

  cyk_pkg::dp_cmd_t dcmd;
  cyk_pkg::dp_sts_t dsts;
  logic busy, str_done, in_fire, start;
  logic [cyk_pkg::COUNT_W-1:0] cnt;
  logic too_long;
  cyk_pkg::cmd_t icmd;

  assign icmd      = cyk_pkg::cmd_t'(in_tdata[1:0]);
  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign start     = in_fire && icmd == cyk_pkg::CMD_BYTE && in_tlast;

  // Overflow seen here includes this byte when the string is already full.
  logic ovf_now;

  cyk_datapath #(
    .MAX_LEN(MAX_LEN), .MAX_NT(MAX_NT),
    .MAX_BIN_RULES(MAX_BIN_RULES), .MAX_TERM_RULES(MAX_TERM_RULES)
  ) u_dp (
    .clk, .rst_n,
    .ld_valid(in_fire), .ld_cmd(icmd),
    .ld_parent(in_tdata[6:2]), .ld_left(in_tdata[11:7]),
    .ld_right(in_tdata[16:12]), .ld_sym(in_tdata[24:17]),
    .str_done, .cmd(dcmd), .sts(dsts), .ovf_pending(ovf_now),
    .res_count(cnt), .res_too_long(too_long)
  );

  cyk_ctrl u_ctrl (
    .clk, .rst_n, .start, .ovf(ovf_now), .sts(dsts), .out_ready(out_tready),
    .cmd(dcmd), .busy, .out_valid(out_tvalid), .str_done
  );

  assign out_tdata = cnt;
  assign out_tuser = too_long;

endmodule
